// File: design/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

  // Default number of entries the queue can hold.
  localparam int unsigned SPQ_CAPACITY = 16;

  // Fixed field widths.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // One stored entry: priority above data.
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = PRIO_W + VALUE_W;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_PUT,
    S_REM
  } spq_state_t;

endpackage

// File: design/spq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and arrives in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: sequencer around one entry RAM.
//
// Usage. An operation beat is taken at a rising edge where start is high and
// busy is low: in_operation selects enqueue, dequeue or delete, in_item_value
// carries the data and in_item_priority the priority for an enqueue.
// Each operation gives exactly one result beat, shown for one cycle while
// out_valid is high: out_status, out_value_out and out_entry_count. The
// receiver cannot stall, so the result must be taken in that cycle.
// Entries are kept in one RAM, highest priority first, equal priorities in
// arrival order. Each operation walks the RAM one entry per cycle, reading
// an entry while the previous one is written back one place along.
// An enqueue walks from the back until it meets an entry of equal or higher
// priority; a dequeue or delete walks over every entry held. A rejected
// operation (full, empty) or an unknown code is answered in the cycle after
// it is accepted. busy is high until the result is issued, and the next
// operation may be accepted in the cycle that the result is shown. The RAM
// read latency and its single write port set the pace of one entry per
// cycle.
// Reset clears the entry count and the sequencer; stored entries are not
// cleared, as only entries below the count are ever read.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = SPQ_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic [PRIO_W-1:0]         in_item_priority,
  output logic                      out_valid,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VALUE_W-1:0] out_value_out,
  output logic [COUNT_W-1:0]        out_entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // Control and payload registers.
  spq_state_t          state_r, state_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                found_r, found_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [PRIO_W-1:0]   prio_r, prio_nxt;
  logic [VALUE_W-1:0]  res_val_r, res_val_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  // RAM port signals.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata_raw;
  entry_t              ram_rdata;

  // Decode helpers.
  logic                take;
  logic                is_last;
  logic                hit;
  entry_t              new_entry;
  logic [CW+COUNT_W-1:0] count_ext;

  assign take      = start && (state_r == S_IDLE);
  assign ram_rdata = entry_t'(ram_rdata_raw);
  assign new_entry = '{prio: prio_r, value: val_r};
  assign is_last   = ((CW'(idx_r) + CW'(1)) == occ_r);
  assign hit       = !found_r &&
                     (((op_r == OP_DEQUEUE) && (idx_r == '0)) ||
                      ((op_r == OP_DELETE) && (ram_rdata.value == val_r)));

  // Entry store.
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (in_operation)
            OP_ENQUEUE: begin
              if (occ_r == CAP_CNT) begin
                state_nxt = S_IDLE;
              end else if (occ_r == '0) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_ENQ;
              end
            end
            OP_DEQUEUE, OP_DELETE: begin
              if (occ_r != '0) begin
                state_nxt = S_REM;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENQ: begin
        if (ram_rdata.prio >= prio_r) begin
          state_nxt = S_IDLE;
        end else if (idx_r == '0) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: state_nxt = S_IDLE;
      S_REM: begin
        if (is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, RAM controls and result of each state.
  always_comb begin
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    prio_nxt       = prio_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = new_entry;
    ram_raddr      = idx_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          op_nxt        = in_operation;
          val_nxt       = in_item_value;
          prio_nxt      = in_item_priority;
          found_nxt     = 1'b0;
          res_val_nxt   = '0;
          out_value_nxt = '0;
          case (in_operation)
            OP_ENQUEUE: begin
              if (occ_r == CAP_CNT) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else if (occ_r == '0) begin
                idx_nxt = '0;
              end else begin
                // Walk from the back of the queue towards the front.
                idx_nxt   = AW'(occ_r - CW'(1));
                ram_raddr = AW'(occ_r - CW'(1));
              end
            end
            OP_DEQUEUE, OP_DELETE: begin
              if (occ_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                ram_raddr = '0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_ENQ: begin
        // Stop behind an entry of equal or higher priority, else move it back.
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        if (ram_rdata.prio >= prio_r) begin
          ram_wdata      = new_entry;
          occ_nxt        = occ_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
        end else begin
          ram_wdata = ram_rdata;
          if (idx_r != '0) begin
            idx_nxt   = idx_r - AW'(1);
            ram_raddr = idx_r - AW'(1);
          end
        end
      end
      S_PUT: begin
        // New entry goes to the front, or into an empty queue.
        ram_we         = 1'b1;
        ram_waddr      = idx_r;
        ram_wdata      = new_entry;
        occ_nxt        = occ_r + CW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_value_nxt  = '0;
      end
      S_REM: begin
        // Find the entry to remove, then close the gap behind it.
        found_nxt = found_r || hit;
        if (hit && (op_r == OP_DEQUEUE)) begin
          res_val_nxt = ram_rdata.value;
        end
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (is_last) begin
          out_valid_nxt = 1'b1;
          if (found_r || hit) begin
            occ_nxt        = occ_r - CW'(1);
            out_status_nxt = ST_OK;
            out_value_nxt  = (hit && (op_r == OP_DEQUEUE)) ? ram_rdata.value : res_val_r;
          end else begin
            out_status_nxt = ST_NOTFOUND;
            out_value_nxt  = '0;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // The reported count is the occupancy after the operation, five bits wide.
  assign count_ext     = {{COUNT_W{1'b0}}, occ_nxt};
  assign out_count_nxt = count_ext[COUNT_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    prio_r       <= prio_nxt;
    res_val_r    <= res_val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_value_r;
  assign out_entry_count = out_count_r;

  // A result beat is only issued once the sequencer is back at rest.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat issued while the sequencer is busy");

  // The occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CAP_CNT)
    else $error("occupancy beyond capacity");

  // An accepted operation either answers at once or keeps the block busy.
  a_take_progress: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_valid_r || busy))
    else $error("accepted operation produced neither result nor busy");

  // A dropped enqueue is only reported on a full queue, which stays full.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (occ_r == CAP_CNT))
    else $error("full status reported on a queue with room");

  // Entries only move while the sequencer walks the RAM.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

endmodule

// File: test/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int CAP = SPQ_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = CAP + 8;
  localparam int RANDOM_PER_PHASE = 342;
  // The operation field has one code the queue does not define; it is ignored.
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  // One result beat as the queue reports it.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } qresult_t;

  // One row of the directed table; fixed_res is used only where typed is set.
  typedef struct packed {
    logic               typed;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    qresult_t           fixed_res;
  } op_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [OP_W-1:0]           in_operation;
  logic signed [VALUE_W-1:0] in_item_value;
  logic [PRIO_W-1:0]         in_item_priority;
  logic                      out_valid;
  logic [STAT_W-1:0]         out_status;
  logic signed [VALUE_W-1:0] out_value_out;
  logic [COUNT_W-1:0]        out_entry_count;

  // Shadow copy of the queue contents, front at index zero.
  logic [VALUE_W-1:0] shadow_value [CAP];
  logic [PRIO_W-1:0]  shadow_prio [CAP];
  int                 shadow_count;

  qresult_t pending_results [$];
  op_row_t  directed_rows [$];

  int errors;
  int cycles;
  int beats_checked;
  int sender_idle_pct;
  int n_enq, n_deq, n_del, n_undef, n_full, n_empty, n_notfound;

  sorted_priority_queue #(.CAPACITY(CAP)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_value_out    (out_value_out),
    .out_entry_count  (out_entry_count)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Global cycle limit in case the queue hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Prints one line per discrepancy and keeps count.
  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Closes the gap left by a removed entry.
  function automatic void shadow_remove(input int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_value[i] = shadow_value[i + 1];
      shadow_prio[i]  = shadow_prio[i + 1];
    end
    shadow_count--;
  endfunction

  // Applies one operation to the shadow queue and returns the result it gives.
  function automatic qresult_t queue_apply(input logic [OP_W-1:0] op,
                                           input logic [VALUE_W-1:0] value,
                                           input logic [PRIO_W-1:0] prio);
    qresult_t res;
    int pos;
    bit hit;
    res = '0;
    pos = 0;
    hit = 1'b0;
    case (op)
      OP_ENQUEUE: begin
        n_enq++;
        if (shadow_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          // A new entry goes behind every entry of equal or higher priority.
          while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_value[i] = shadow_value[i - 1];
            shadow_prio[i]  = shadow_prio[i - 1];
          end
          shadow_value[pos] = value;
          shadow_prio[pos]  = prio;
          shadow_count++;
        end
      end
      OP_DEQUEUE: begin
        n_deq++;
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = shadow_value[0];
          shadow_remove(0);
        end
      end
      OP_DELETE: begin
        n_del++;
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Only the first match in queue order is removed.
          while (pos < shadow_count && !hit) begin
            if (shadow_value[pos] == value) hit = 1'b1;
            else pos++;
          end
          if (hit) shadow_remove(pos);
          else res.status = ST_NOTFOUND;
        end
      end
      default: begin
        n_undef++;
      end
    endcase
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_EMPTY) n_empty++;
    if (res.status == ST_NOTFOUND) n_notfound++;
    res.count = shadow_count[COUNT_W-1:0];
    return res;
  endfunction

  // Drives one operation beat, waits for it to be taken and records its result.
  task automatic issue_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                          input logic [PRIO_W-1:0] prio, input logic typed,
                          input qresult_t fixed_res);
    qresult_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start            = 1'b1;
    in_operation     = op;
    in_item_value    = value;
    in_item_priority = prio;
    do @(posedge clk); while (busy !== 1'b0);
    res = queue_apply(op, value, prio);
    pending_results.push_back(typed ? fixed_res : res);
  endtask

  // Lowers start and holds off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Adds one row to the directed table.
  task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                         input logic [PRIO_W-1:0] prio, input logic typed,
                         input logic [STAT_W-1:0] st, input logic [VALUE_W-1:0] vout,
                         input int cnt);
    op_row_t row;
    row.typed            = typed;
    row.op               = op;
    row.value            = value;
    row.prio             = prio;
    row.fixed_res.status = st;
    row.fixed_res.value  = vout;
    row.fixed_res.count  = cnt[COUNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Result checker: each beat is compared with the oldest outstanding result.
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_valid === 1'b1) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result beat with no operation outstanding: st=%0d val=%0h cnt=%0d",
                               out_status, out_value_out, out_entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_error($sformatf("beat %0d status: expected %0d, got %0d",
                                 beats_checked, want.status, out_status));
        if (out_value_out !== want.value)
          report_error($sformatf("beat %0d value_out: expected %0h, got %0h",
                                 beats_checked, want.value, out_value_out));
        if (out_entry_count !== want.count)
          report_error($sformatf("beat %0d entry_count: expected %0d, got %0d",
                                 beats_checked, want.count, out_entry_count));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    int enq_pct;
    int roll;
    bit narrow_prio;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_operation     = OP_ENQUEUE;
    in_item_value    = '0;
    in_item_priority = '0;
    errors           = 0;
    cycles           = 0;
    beats_checked    = 0;
    sender_idle_pct  = 0;
    shadow_count     = 0;
    enq_pct          = 50;
    narrow_prio      = 1'b0;
    {n_enq, n_deq, n_del, n_undef, n_full, n_empty, n_notfound} = '0;

    // Directed table: empty-queue errors, the unknown code, extremes, ties and a full queue.
    add_row(OP_DEQUEUE, 32'd5, 8'd0, 1'b1, ST_EMPTY, 32'd0, 0);
    add_row(OP_DELETE, 32'd5, 8'd0, 1'b1, ST_EMPTY, 32'd0, 0);
    add_row(OP_UNDEF, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_OK, 32'd0, 0);
    add_row(OP_ENQUEUE, 32'h8000_0000, 8'd0, 1'b1, ST_OK, 32'd0, 1);
    add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 8'd255, 1'b1, ST_OK, 32'd0, 2);
    add_row(OP_DELETE, 32'd0, 8'd0, 1'b1, ST_NOTFOUND, 32'd0, 2);
    add_row(OP_DEQUEUE, 32'd0, 8'd0, 1'b1, ST_OK, 32'h7FFF_FFFF, 1);
    for (int i = 0; i < CAP - 1; i++)
      add_row(OP_ENQUEUE, 32'h100 + i, 8'((i % 3) * 100), 1'b0, ST_OK, 32'd0, 0);
    add_row(OP_ENQUEUE, 32'hFFFF_FFFF, 8'd255, 1'b1, ST_FULL, 32'd0, CAP);
    add_row(OP_DELETE, 32'h105, 8'd0, 1'b0, ST_OK, 32'd0, 0);
    add_row(OP_DEQUEUE, 32'd0, 8'd0, 1'b0, ST_OK, 32'd0, 0);

    // Hold the synchronous reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      issue_op(directed_rows[i].op, directed_rows[i].value, directed_rows[i].prio,
               directed_rows[i].typed, directed_rows[i].fixed_res);
    wait_drained();

    // Random traffic in three phases of sender idling: 30 %, 53 %, then none.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 53 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Every forty beats the mix shifts, so the queue both fills and drains.
        if (n % 40 == 0) begin
          enq_pct     = $urandom_range(15, 85);
          narrow_prio = 1'($urandom_range(0, 1));
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) op = OP_UNDEF;
        else if (roll < 3 + enq_pct) op = OP_ENQUEUE;
        else if ($urandom_range(0, 1) == 1) op = OP_DEQUEUE;
        else op = OP_DELETE;

        // Data: mostly a small signed pool so duplicates occur, some wide values and extremes.
        roll = $urandom_range(0, 99);
        if (roll < 60) value = int'($urandom_range(0, 15)) - 8;
        else if (roll < 90) value = $urandom;
        else begin
          case ($urandom_range(0, 3))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h0;
            default: value = 32'hFFFF_FFFF;
          endcase
        end
        // Deletes mostly name a value that is held somewhere in the queue.
        if (op == OP_DELETE && shadow_count > 0 && $urandom_range(0, 99) < 70)
          value = shadow_value[$urandom_range(0, shadow_count - 1)];
        prio = narrow_prio ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));

        issue_op(op, value, prio, 1'b0, '0);
      end
      wait_drained();
    end

    // Let any late beat show itself before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d operations: %0d enqueue, %0d dequeue, %0d delete, %0d unknown code.",
             n_enq + n_deq + n_del + n_undef, n_enq, n_deq, n_del, n_undef);
    $display("Error paths hit: %0d full, %0d empty, %0d not found; %0d result beats checked.",
             n_full, n_empty, n_notfound, beats_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/spq_pkg.sv
design/spq_ram.sv
design/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
